// File: design/ddo_pkg.sv
package ddo_pkg;

  localparam int DIV_BITS         = 68;
  localparam int CNT_W            = 7;
  localparam int CORDIC_STEPS_DEF = 24;

  localparam logic [31:0] DPC_RESET = 32'd340818;
  localparam logic [31:0] HG_RESET  = 32'd44700000;

  localparam logic signed [33:0] CORDIC_START = 34'sd652032874;
  localparam logic signed [33:0] Q30_ONE      = 34'sd1073741824;
  localparam logic [63:0]        VEL_SCALE    = 64'd1000000;
  localparam logic [63:0]        ANG_SCALE    = 64'd823549664582;

  localparam logic [3:0] J_DS    = 4'd0;
  localparam logic [3:0] J_TH    = 4'd1;
  localparam logic [3:0] J_CMID  = 4'd2;
  localparam logic [3:0] J_X     = 4'd3;
  localparam logic [3:0] J_Y     = 4'd4;
  localparam logic [3:0] J_CHEAD = 4'd5;
  localparam logic [3:0] J_MV    = 4'd6;
  localparam logic [3:0] J_DV    = 4'd7;
  localparam logic [3:0] J_MW    = 4'd8;
  localparam logic [3:0] J_DW    = 4'd9;

  localparam logic [1:0] K_MUL = 2'd0;
  localparam logic [1:0] K_COR = 2'd1;
  localparam logic [1:0] K_DIV = 2'd2;

  localparam logic CFG_DPC = 1'b0;
  localparam logic CFG_HG  = 1'b1;

  typedef struct packed {
    logic [3:0]       job;
    logic             init;
    logic             step;
    logic             fin;
    logic             load;
    logic             prime;
    logic             emit;
    logic [CNT_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic dt_zero;
  } sts_t;

  function automatic logic [1:0] job_kind(input logic [3:0] job);
    logic [1:0] k;
    case (job) inside
      J_CMID, J_CHEAD: k = K_COR;
      J_DV, J_DW:      k = K_DIV;
      default:         k = K_MUL;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] atan_lut(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      5'd24: v = 32'd41;
      5'd25: v = 32'd20;
      5'd26: v = 32'd10;
      5'd27: v = 32'd5;
      5'd28: v = 32'd3;
      5'd29: v = 32'd1;
      5'd30: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

// File: design/ddo_ctrl.sv
module ddo_ctrl #(
  parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  ddo_pkg::sts_t sts,
  output ddo_pkg::cmd_t cmd
);
  import ddo_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [3:0]       job_r, job_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             primed_r, primed_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0] nsteps;

  always_comb begin
    case (job_kind(job_r))
      K_COR:   nsteps = CNT_W'(CORDIC_STEPS);
      K_DIV:   nsteps = CNT_W'(DIV_BITS);
      default: nsteps = CNT_W'(4);
    endcase
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    job_nxt       = job_r;
    cnt_nxt       = cnt_r;
    primed_nxt    = primed_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    cmd.job       = job_r;
    cmd.idx       = cnt_r - CNT_W'(1);
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (!primed_r || sts.dt_zero) begin
            cmd.prime  = 1'b1;
            primed_nxt = 1'b1;
          end else begin
            cmd.load  = 1'b1;
            state_nxt = ST_RUN;
            job_nxt   = J_DS;
            cnt_nxt   = '0;
          end
        end
      end
      ST_RUN: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == '0) begin
          cmd.init = 1'b1;
        end else if (cnt_r <= nsteps) begin
          cmd.step = 1'b1;
        end else begin
          cmd.fin = 1'b1;
          cnt_nxt = '0;
          if (job_r == J_DW) begin
            state_nxt = ST_OUT;
          end else begin
            job_nxt = job_r + 4'd1;
          end
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      job_r       <= J_DS;
      cnt_r       <= '0;
      primed_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      job_r       <= job_nxt;
      cnt_r       <= cnt_nxt;
      primed_r    <= primed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RUN |-> cnt_r <= nsteps + CNT_W'(1))
    else $error("step counter overran");
  a_prime_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.prime |=> state_r == ST_IDLE && primed_r)
    else $error("prime left idle");
  a_primed_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !$fell(primed_r))
    else $error("primed flag dropped");
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !out_valid_r || out_ready)
    else $error("result overwritten");
`endif

endmodule

// File: design/ddo_dp.sv
module ddo_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  ddo_pkg::cmd_t       cmd,
  output ddo_pkg::sts_t       sts,
  input  logic [31:0]         dpc,
  input  logic [31:0]         hg,
  input  logic signed [31:0]  in_left_count,
  input  logic signed [31:0]  in_right_count,
  input  logic [31:0]         in_elapsed_us,
  output logic signed [47:0]  out_pos_x,
  output logic signed [47:0]  out_pos_y,
  output logic [31:0]         out_heading_angle,
  output logic signed [31:0]  out_quat_z,
  output logic signed [31:0]  out_quat_w,
  output logic signed [31:0]  out_linear_velocity,
  output logic signed [31:0]  out_angular_velocity
);
  import ddo_pkg::*;

  logic [31:0]  last_l_r, last_rt_r, dt_r, heading_r;
  logic [32:0]  sum_abs_r;
  logic [31:0]  diff_abs_r;
  logic         sum_neg_r, diff_neg_r;
  logic [63:0]  ds_mag_r, th_mag_r;
  logic [47:0]  pos_x_r, pos_y_r;
  logic [31:0]  cos_r, sin_r, qz_r, qw_r, lin_r, ang_r;
  logic [127:0] acc_r;
  logic [63:0]  prod_r;
  logic [1:0]   psh_r;
  logic signed [33:0] cx_r, cy_r, cz_r;
  logic         flip_r;
  logic [DIV_BITS-1:0] dvd_r;
  logic [31:0]  rem_r;
  logic [32:0]  q_r;
  logic         ovf_r;
  logic [47:0]  o_px_r, o_py_r;
  logic [31:0]  o_hd_r, o_qz_r, o_qw_r, o_lv_r, o_av_r;

  logic [31:0]  dl_u, dr_u;
  logic signed [32:0] dl, dr;
  logic signed [33:0] sum_s, diff_s;
  logic [63:0]  op_a, op_b;
  logic [CNT_W-1:0] idx_inc;
  logic [1:0]   k;
  logic [31:0]  aw, bw;
  logic [127:0] pp_sh;
  logic [31:0]  cos_abs, sin_abs, half, full, mid, cang, ctmp;
  logic [47:0]  res_x, res_y;
  logic [4:0]   ci;
  logic signed [33:0] dx, dy, atn, clx, cly;
  logic [32:0]  rsh, rdiff;
  logic         ge, dneg;
  logic [32:0]  limit, sat;
  logic [31:0]  vres;
  logic [1:0]   kind;

  assign sts.dt_zero = (in_elapsed_us == 32'd0);
  assign kind = job_kind(cmd.job);

  // wheel deltas on the 32-bit ring
  always_comb begin
    dl_u   = in_left_count - last_l_r;
    dr_u   = in_right_count - last_rt_r;
    dl     = {dl_u > 32'h8000_0000, dl_u};
    dr     = {dr_u > 32'h8000_0000, dr_u};
    sum_s  = 34'(dl) + 34'(dr);
    diff_s = 34'(dr) - 34'(dl);
  end

  always_comb begin
    cos_abs = cos_r[31] ? 32'(-cos_r) : cos_r;
    sin_abs = sin_r[31] ? 32'(-sin_r) : sin_r;
    case (cmd.job)
      J_DS:    begin op_a = {31'd0, sum_abs_r};  op_b = {32'd0, dpc};     end
      J_TH:    begin op_a = {32'd0, diff_abs_r}; op_b = {32'd0, hg};      end
      J_X:     begin op_a = ds_mag_r;            op_b = {32'd0, cos_abs}; end
      J_Y:     begin op_a = ds_mag_r;            op_b = {32'd0, sin_abs}; end
      J_MV:    begin op_a = ds_mag_r;            op_b = VEL_SCALE;        end
      J_MW:    begin op_a = th_mag_r;            op_b = ANG_SCALE;        end
      default: begin op_a = '0;                  op_b = '0;               end
    endcase
    idx_inc = cmd.idx + CNT_W'(1);
    k  = cmd.init ? 2'd0 : idx_inc[1:0];
    aw = k[0] ? op_a[63:32] : op_a[31:0];
    bw = k[1] ? op_b[63:32] : op_b[31:0];
    case (psh_r)
      2'd0:    pp_sh = {64'd0, prod_r};
      2'd1:    pp_sh = {32'd0, prod_r, 32'd0};
      default: pp_sh = {prod_r, 64'd0};
    endcase
  end

  always_comb begin
    half  = th_mag_r[40:9];
    full  = th_mag_r[39:8];
    mid   = diff_neg_r ? heading_r - half : heading_r + half;
    cang  = (cmd.job == J_CMID) ? {mid[30:0], 1'b0} : heading_r;
    ctmp  = cang + 32'h4000_0000;
    res_x = acc_r[77:30];
    res_y = acc_r[77:30];
    ci    = cmd.idx[4:0];
    dx    = cx_r >>> ci;
    dy    = cy_r >>> ci;
    atn   = {2'b00, atan_lut(ci)};
    clx   = (cx_r > Q30_ONE) ? Q30_ONE : ((cx_r < -Q30_ONE) ? -Q30_ONE : cx_r);
    cly   = (cy_r > Q30_ONE) ? Q30_ONE : ((cy_r < -Q30_ONE) ? -Q30_ONE : cy_r);
    if (flip_r) begin
      clx = -clx;
      cly = -cly;
    end
  end

  always_comb begin
    rsh   = {rem_r, dvd_r[DIV_BITS-1]};
    ge    = rsh >= {1'b0, dt_r};
    rdiff = rsh - {1'b0, dt_r};
    dneg  = (cmd.job == J_DV) ? sum_neg_r : diff_neg_r;
    limit = dneg ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
    sat   = (ovf_r || q_r > limit) ? limit : q_r;
    vres  = dneg ? 32'(-sat) : sat[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_l_r  <= '0;
      last_rt_r <= '0;
      heading_r <= '0;
      pos_x_r   <= '0;
      pos_y_r   <= '0;
    end else begin
      if (cmd.prime || cmd.load) begin
        last_l_r  <= in_left_count;
        last_rt_r <= in_right_count;
      end
      if (cmd.fin && cmd.job == J_X) begin
        pos_x_r   <= (sum_neg_r ^ cos_r[31]) ? pos_x_r - res_x : pos_x_r + res_x;
        heading_r <= diff_neg_r ? heading_r - full : heading_r + full;
      end
      if (cmd.fin && cmd.job == J_Y) begin
        pos_y_r <= (sum_neg_r ^ sin_r[31]) ? pos_y_r - res_y : pos_y_r + res_y;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dt_r       <= in_elapsed_us;
      sum_neg_r  <= sum_s[33];
      sum_abs_r  <= sum_s[33] ? 33'(-sum_s) : sum_s[32:0];
      diff_neg_r <= diff_s[33];
      diff_abs_r <= diff_s[33] ? 32'(-diff_s) : diff_s[31:0];
    end
    if (kind == K_MUL) begin
      if (cmd.init) begin
        acc_r <= '0;
      end else if (cmd.step) begin
        acc_r <= acc_r + pp_sh;
      end
      if (cmd.init || cmd.step) begin
        prod_r <= aw * bw;
        psh_r  <= 2'({1'b0, k[0]} + {1'b0, k[1]});
      end
      if (cmd.fin) begin
        case (cmd.job)
          J_DS:    ds_mag_r <= acc_r[64:1];
          J_TH:    th_mag_r <= acc_r[63:0];
          default: ;
        endcase
      end
    end
    if (kind == K_COR) begin
      if (cmd.init) begin
        flip_r <= ctmp[31];
        cz_r   <= ctmp[31] ? 34'(signed'(cang + 32'h8000_0000)) : 34'(signed'(cang));
        cx_r   <= CORDIC_START;
        cy_r   <= '0;
      end else if (cmd.step) begin
        if (!cz_r[33]) begin
          cx_r <= cx_r - dy;
          cy_r <= cy_r + dx;
          cz_r <= cz_r - atn;
        end else begin
          cx_r <= cx_r + dy;
          cy_r <= cy_r - dx;
          cz_r <= cz_r + atn;
        end
      end else if (cmd.fin) begin
        if (cmd.job == J_CMID) begin
          cos_r <= clx[31:0];
          sin_r <= cly[31:0];
        end else begin
          qw_r <= clx[31:0];
          qz_r <= cly[31:0];
        end
      end
    end
    if (kind == K_DIV) begin
      if (cmd.init) begin
        dvd_r <= (cmd.job == J_DV) ? acc_r[DIV_BITS+15:16] : acc_r[DIV_BITS+39:40];
        rem_r <= '0;
        q_r   <= '0;
        ovf_r <= 1'b0;
      end else if (cmd.step) begin
        dvd_r <= {dvd_r[DIV_BITS-2:0], 1'b0};
        rem_r <= ge ? rdiff[31:0] : rsh[31:0];
        q_r   <= {q_r[31:0], ge};
        ovf_r <= ovf_r | q_r[32];
      end else if (cmd.fin) begin
        if (cmd.job == J_DV) begin
          lin_r <= vres;
        end else begin
          ang_r <= vres;
        end
      end
    end
    if (cmd.emit) begin
      o_px_r <= pos_x_r;
      o_py_r <= pos_y_r;
      o_hd_r <= heading_r;
      o_qz_r <= qz_r;
      o_qw_r <= qw_r;
      o_lv_r <= lin_r;
      o_av_r <= ang_r;
    end
  end

  assign out_pos_x            = o_px_r;
  assign out_pos_y            = o_py_r;
  assign out_heading_angle    = o_hd_r;
  assign out_quat_z           = o_qz_r;
  assign out_quat_w           = o_qw_r;
  assign out_linear_velocity  = o_lv_r;
  assign out_angular_velocity = o_av_r;

endmodule

// File: design/diff_drive_wheel_odometry.sv
// Differential-drive odometry with midpoint integration. An input transfer
// carries both absolute encoder counts and the microseconds since the last
// sample; the first transfer after reset, or one with zero elapsed time, only
// records the counts and yields no result. Any other transfer yields one result
// transfer (pose in Q16.32 m, heading as a binary angle with 2^32 = 4*pi, the
// half-yaw quaternion terms in Q1.30, speeds in Q16.16 saturated). The work runs
// on one sequencer over a 32x32 multiplier accumulating four partial products
// per product (six products), a CORDIC rotator run twice, and a one-bit-per-cycle
// 68-step divider run twice. A new transfer is taken while a finished result
// still waits on the output. Registers: distance per count at 0x0, heading
// gain at 0x4; write them only while the block is idle.
module diff_drive_wheel_odometry #(
  parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_left_count,
  input  logic signed [31:0] in_right_count,
  input  logic [31:0]        in_elapsed_us,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [47:0] out_pos_x,
  output logic signed [47:0] out_pos_y,
  output logic [31:0]        out_heading_angle,
  output logic signed [31:0] out_quat_z,
  output logic signed [31:0] out_quat_w,
  output logic signed [31:0] out_linear_velocity,
  output logic signed [31:0] out_angular_velocity
);
  import ddo_pkg::*;

  logic [31:0] dpc_r, hg_r;
  logic        wr;
  cmd_t        cmd;
  sts_t        sts;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == CFG_HG) ? hg_r : dpc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dpc_r <= DPC_RESET;
      hg_r  <= HG_RESET;
    end else if (wr) begin
      unique case (paddr[2])
        CFG_DPC: dpc_r <= pwdata;
        CFG_HG:  hg_r  <= pwdata;
        default: ;
      endcase
    end
  end

  ddo_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ddo_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .dpc                  (dpc_r),
    .hg                   (hg_r),
    .in_left_count        (in_left_count),
    .in_right_count       (in_right_count),
    .in_elapsed_us        (in_elapsed_us),
    .out_pos_x            (out_pos_x),
    .out_pos_y            (out_pos_y),
    .out_heading_angle    (out_heading_angle),
    .out_quat_z           (out_quat_z),
    .out_quat_w           (out_quat_w),
    .out_linear_velocity  (out_linear_velocity),
    .out_angular_velocity (out_angular_velocity)
  );

endmodule

// File: tb/sv/diff_drive_wheel_odometry_tb.sv
`timescale 1ns / 100ps

module diff_drive_wheel_odometry_tb;
  import ddo_pkg::*;

  localparam logic [2:0] ADDR_DIST_PER_COUNT = 3'd0;
  localparam logic [2:0] ADDR_HEADING_GAIN   = 3'd4;
  localparam int         CORDIC_ITERS        = CORDIC_STEPS_DEF;
  localparam int         DRAIN_CYCLES        = 2 * CORDIC_STEPS_DEF + 182 + 100;
  localparam longint     CYCLE_LIMIT         = 4000000;

  typedef struct {
    logic [31:0] left;
    logic [31:0] right;
    logic [31:0] dt;
  } sample_t;

  typedef struct {
    logic [47:0] px;
    logic [47:0] py;
    logic [31:0] heading;
    logic [31:0] qz;
    logic [31:0] qw;
    logic [31:0] lin;
    logic [31:0] ang;
  } pose_t;

  localparam logic [31:0] ATAN_Q32 [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
  };

  logic clk;
  logic rst_n;
  logic psel, penable, pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;
  logic in_valid, in_ready;
  logic signed [31:0] in_left_count, in_right_count;
  logic [31:0] in_elapsed_us;
  logic out_valid, out_ready;
  logic signed [47:0] out_pos_x, out_pos_y;
  logic [31:0] out_heading_angle;
  logic signed [31:0] out_quat_z, out_quat_w, out_linear_velocity, out_angular_velocity;

  diff_drive_wheel_odometry DUT (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_left_count(in_left_count), .in_right_count(in_right_count),
    .in_elapsed_us(in_elapsed_us),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_pos_x(out_pos_x), .out_pos_y(out_pos_y),
    .out_heading_angle(out_heading_angle),
    .out_quat_z(out_quat_z), .out_quat_w(out_quat_w),
    .out_linear_velocity(out_linear_velocity),
    .out_angular_velocity(out_angular_velocity)
  );

  sample_t pending_samples[$];
  pose_t   expected_poses[$];
  int      errors = 0;
  longint  cycles = 0;
  int      transfers_out = 0;
  int      gap_left = 0;
  int      stall_left = 0;
  bit      long_hold_done = 0;

  logic [31:0] dist_scale   = DPC_RESET;
  logic [31:0] heading_gain = HG_RESET;
  logic [31:0] prev_left, prev_right, yaw;
  logic [47:0] x_acc, y_acc;
  bit          primed;

  logic [31:0] gen_left = 0, gen_right = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int idle_gap();
    if ($urandom_range(0, 99) < 60) return 0;
    if ($urandom_range(0, 99) < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 300);
  endfunction

  task automatic report(input string field, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch on %s: got %h, want %h", field, got, want);
    errors++;
  endtask

  function automatic longint wheel_step(input logic [31:0] cur, input logic [31:0] prev);
    logic [31:0] d;
    d = cur - prev;
    if (d > 32'h8000_0000) return longint'({32'b0, d}) - 64'sd4294967296;
    return longint'({32'b0, d});
  endfunction

  task automatic rotate(input logic [31:0] angle, output longint cosv, output longint sinv);
    logic [31:0] r;
    bit flip;
    longint x, y, z, dx, dy;
    r = angle;
    flip = 0;
    x = 652032874;
    y = 0;
    if (((angle + 32'h4000_0000) & 32'h8000_0000) != 0) begin
      r = angle + 32'h8000_0000;
      flip = 1;
    end
    z = longint'($signed(r));
    for (int i = 0; i < CORDIC_ITERS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - longint'({32'b0, ATAN_Q32[i]});
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + longint'({32'b0, ATAN_Q32[i]});
      end
    end
    if (x > 1073741824) x = 1073741824;
    if (x < -1073741824) x = -1073741824;
    if (y > 1073741824) y = 1073741824;
    if (y < -1073741824) y = -1073741824;
    cosv = flip ? -x : x;
    sinv = flip ? -y : y;
  endtask

  function automatic logic [63:0] scale_q30(input logic [63:0] mag, input bit neg,
                                            input longint t);
    logic [127:0] prod;
    logic [63:0] res, tm;
    bit tneg;
    tneg = t < 0;
    tm = tneg ? 64'(-t) : 64'(t);
    prod = {64'b0, mag} * {64'b0, tm};
    res = prod[93:30];
    return (neg != tneg) ? -res : res;
  endfunction

  function automatic logic [31:0] rate(input logic [127:0] a, input logic [127:0] b,
                                       input int sh, input logic [31:0] c, input bit neg);
    logic [127:0] q, lim;
    logic [63:0] v;
    q = ((a * b) >> sh) / {96'b0, c};
    lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
    if (q > lim) q = lim;
    v = q[63:0];
    if (neg) v = -v;
    return v[31:0];
  endfunction

  task automatic integrate_sample(input sample_t s);
    longint dl, dr, sum, diff, cs, sn, qz, qw;
    logic [127:0] ds_mag, th_mag;
    logic [31:0] half, full, mid;
    bit ds_neg, th_neg;
    pose_t p;
    if (!primed || s.dt == 0) begin
      prev_left = s.left;
      prev_right = s.right;
      primed = 1;
      return;
    end
    dl = wheel_step(s.left, prev_left);
    dr = wheel_step(s.right, prev_right);
    prev_left = s.left;
    prev_right = s.right;
    sum = dl + dr;
    ds_neg = sum < 0;
    ds_mag = ({64'b0, 64'(ds_neg ? -sum : sum)} * {96'b0, dist_scale}) >> 1;
    diff = dr - dl;
    th_neg = diff < 0;
    th_mag = {64'b0, 64'(th_neg ? -diff : diff)} * {96'b0, heading_gain};
    half = th_mag[40:9];
    full = th_mag[39:8];
    mid = th_neg ? yaw - half : yaw + half;
    rotate(mid << 1, cs, sn);
    x_acc = x_acc + 48'(scale_q30(ds_mag[63:0], ds_neg, cs));
    y_acc = y_acc + 48'(scale_q30(ds_mag[63:0], ds_neg, sn));
    yaw = th_neg ? yaw - full : yaw + full;
    rotate(yaw, qw, qz);
    p.px = x_acc;
    p.py = y_acc;
    p.heading = yaw;
    p.qz = qz[31:0];
    p.qw = qw[31:0];
    p.lin = rate(ds_mag, 128'(VEL_SCALE), 16, s.dt, ds_neg);
    p.ang = rate(th_mag, 128'(ANG_SCALE), 40, s.dt, th_neg);
    expected_poses.push_back(p);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_left_count <= '0;
      in_right_count <= '0;
      in_elapsed_us <= '0;
      gap_left <= 0;
    end else begin
      if (in_valid && in_ready)
        integrate_sample('{in_left_count, in_right_count, in_elapsed_us});
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_samples.size() > 0) begin
          sample_t s;
          s = pending_samples.pop_front();
          in_left_count <= s.left;
          in_right_count <= s.right;
          in_elapsed_us <= s.dt;
          in_valid <= 1'b1;
          gap_left <= idle_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_poses.size() == 0) begin
          $display("result transfer with nothing expected");
          errors++;
        end else begin
          pose_t e;
          e = expected_poses.pop_front();
          if (out_pos_x !== e.px) report("pos_x", 64'(out_pos_x), 64'(e.px));
          if (out_pos_y !== e.py) report("pos_y", 64'(out_pos_y), 64'(e.py));
          if (out_heading_angle !== e.heading)
            report("heading_angle", 64'(out_heading_angle), 64'(e.heading));
          if (out_quat_z !== e.qz) report("quat_z", 64'(out_quat_z), 64'(e.qz));
          if (out_quat_w !== e.qw) report("quat_w", 64'(out_quat_w), 64'(e.qw));
          if (out_linear_velocity !== e.lin)
            report("linear_velocity", 64'(out_linear_velocity), 64'(e.lin));
          if (out_angular_velocity !== e.ang)
            report("angular_velocity", 64'(out_angular_velocity), 64'(e.ang));
        end
        transfers_out <= transfers_out + 1;
      end
      if (!long_hold_done && transfers_out == 150) begin
        long_hold_done <= 1;
        stall_left <= 3000;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ready <= 1'b0;
      end else if (out_ready && $urandom_range(0, 99) < 25) begin
        stall_left <= idle_gap();
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("diff_drive_wheel_odometry_tb failed");
      $finish;
    end
  end

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (addr == ADDR_DIST_PER_COUNT) dist_scale = data;
    else if (addr == ADDR_HEADING_GAIN) heading_gain = data;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic queue_sample(input logic [31:0] l, input logic [31:0] r, input logic [31:0] dt);
    pending_samples.push_back('{l, r, dt});
    gen_left = l;
    gen_right = r;
  endtask

  task automatic wait_idle();
    wait (pending_samples.size() == 0 && !in_valid && expected_poses.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic queue_random(input int n);
    int pick;
    logic [31:0] dt;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      dt = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(500, 20000);
      if (pick < 4)
        queue_sample($urandom(), $urandom(), 32'd0);
      else if (pick < 10)
        queue_sample($urandom(), $urandom(), ($urandom_range(0, 1) != 0) ? $urandom() : 32'd1);
      else if (pick < 15)
        queue_sample(gen_left + $urandom_range(0, 200), gen_right + $urandom_range(0, 200),
                     $urandom_range(1, 3));
      else
        queue_sample(gen_left + 32'($signed($urandom_range(0, 4000)) - 2000),
                     gen_right + 32'($signed($urandom_range(0, 4000)) - 2000), dt);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    prev_left = 0;
    prev_right = 0;
    yaw = 0;
    x_acc = 0;
    y_acc = 0;
    primed = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    queue_sample(32'd0, 32'd0, 32'd1000);
    queue_sample(32'd100, 32'd100, 32'd1000);
    queue_sample(32'd50, 32'd150, 32'd1000);
    queue_sample(32'd300, 32'd100, 32'd1000);
    queue_sample(32'd300, 32'd100, 32'd0);
    queue_sample(32'h8000_012C, 32'h8000_0064, 32'd1);
    queue_sample(32'h0000_012C, 32'h8000_0064, 32'hFFFF_FFFF);
    queue_sample(32'h8000_012D, 32'h0000_0065, 32'd1);
    queue_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'd7);
    queue_sample(32'hFFFF_FFFF, 32'h0000_0000, 32'd1);
    queue_sample(32'hFFFF_FFFF, 32'h0000_0000, 32'd2);
    queue_sample(32'h0000_0010, 32'hFFFF_FFF0, 32'd5000);
    queue_sample(32'h0000_0010, 32'hFFFF_FFF0, 32'hFFFF_FFFF);
    wait_idle();

    reg_write(ADDR_DIST_PER_COUNT, 32'hFFFF_FFFF);
    reg_write(ADDR_HEADING_GAIN, 32'hFFFF_FFFF);
    queue_sample(32'h8000_0010, 32'h8000_0010, 32'd1);
    queue_sample(32'h0000_0010, 32'h8000_0010, 32'd1);
    queue_sample(32'h8000_0011, 32'h8000_0010, 32'hFFFF_FFFF);
    queue_random(300);
    wait_idle();

    reg_write(ADDR_DIST_PER_COUNT, 32'd0);
    reg_write(ADDR_HEADING_GAIN, 32'd0);
    queue_random(150);
    wait_idle();

    reg_write(ADDR_DIST_PER_COUNT, $urandom());
    reg_write(ADDR_HEADING_GAIN, $urandom());
    queue_random(350);
    wait_idle();

    reg_write(ADDR_DIST_PER_COUNT, $urandom_range(1, 1 << 24));
    reg_write(ADDR_HEADING_GAIN, $urandom_range(1 << 20, 1 << 28));
    queue_random(350);
    wait_idle();

    reg_write(ADDR_DIST_PER_COUNT, DPC_RESET);
    reg_write(ADDR_HEADING_GAIN, HG_RESET);
    queue_random(350);
    wait_idle();

    if (expected_poses.size() != 0) begin
      $display("%0d results never arrived", expected_poses.size());
      errors++;
    end
    if (errors == 0)
      $display("diff_drive_wheel_odometry_tb passed");
    else
      $display("diff_drive_wheel_odometry_tb failed");
    $finish;
  end

endmodule
